[design/assert_macros.svh]
// assertion macros shared by the mass-spring step unit rtl
// no dependencies; define NO_ASSERTIONS to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MS_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MS_ASSERT(lbl, clk, rst_n, prop, msg)
`define MS_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

[design/msstep_pkg.sv]
// types, constants and saturation helpers for the mass-spring step unit
// no dependencies
`default_nettype none
package msstep_pkg;
    localparam int PARTICLE_COUNT_DEF = 1024;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [6:0]  DT_MAX     = 7'd66;
    localparam logic [6:0]  TS_RESET   = 7'd66;
    localparam logic [16:0] DAMP_RESET = 17'd65536;
    localparam logic REG_TIME_STEP = 1'b0;
    localparam logic REG_DAMPING   = 1'b1;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_SPRING = 2'd1,
        MODE_INTEG  = 2'd2
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [9:0]         a;
        logic [9:0]         b;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [30:0]        mos;
        logic [30:0]        rest;
        logic [30:0]        cdamp;
    } t_cmd;

    typedef struct packed {
        logic [6:0]  dt;
        logic [16:0] damp;
    } t_cfg;

    typedef enum logic [4:0] {
        S_IDLE, S_LD_WR,
        S_SP_RDA, S_SP_RDB, S_SP_GETB, S_SP_SQ, S_SP_SQACC, S_SP_CHK, S_SP_SQRTW,
        S_SP_DIV, S_SP_DIVW, S_SP_FE, S_SP_FEG, S_SP_DOT, S_SP_DOTACC, S_SP_FV,
        S_SP_FVG, S_SP_F1, S_SP_F1G, S_SP_F2G, S_SP_WRA, S_SP_WRB,
        S_IN_RD, S_IN_GET, S_IN_DIV, S_IN_DIVW, S_IN_V, S_IN_VG, S_IN_DG, S_IN_PG,
        S_IN_WR, S_MULW
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        else if (v < -66'sd2147483648) return 32'sh80000000;
        else return signed'(v[31:0]);
    endfunction

    function automatic logic signed [31:0] qsat(input logic signed [65:0] p);
        return sat32(p >>> 16);
    endfunction
endpackage
`default_nettype wire

[design/msstep_front.sv]
// front end: accepts requests, drops out-of-range or unknown ones, queues the rest
// depends on msstep_pkg
`default_nettype none
module msstep_front
    import msstep_pkg::*;
#(
    parameter int PARTICLE_COUNT = PARTICLE_COUNT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_mode,
    input  wire logic [9:0]         i_first_index,
    input  wire logic [9:0]         i_second_index,
    input  wire logic signed [31:0] i_vec_x,
    input  wire logic signed [31:0] i_vec_y,
    input  wire logic signed [31:0] i_vec_z,
    input  wire logic [30:0]        i_mass_or_stiffness,
    input  wire logic [30:0]        i_rest_length,
    input  wire logic [30:0]        i_spring_damping,
    output logic                    o_cmd_valid,
    input  wire logic               i_cmd_pop,
    output t_cmd                    o_cmd
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    t_cmd           r_q [QUEUE_DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [PW:0]    r_cnt;
    logic           a_ok, b_ok, keep, push;
    t_cmd           cmd;

    assign a_ok = 32'(i_first_index) < PARTICLE_COUNT;
    assign b_ok = 32'(i_second_index) < PARTICLE_COUNT;

    always_comb begin
        keep = 1'b0;
        case (i_mode)
            MODE_LOAD:   keep = a_ok;
            MODE_SPRING: keep = a_ok && b_ok;
            MODE_INTEG:  keep = a_ok;
            default:     keep = 1'b0;
        endcase
    end

    always_comb begin
        cmd.mode  = t_mode'(i_mode);
        cmd.a     = i_first_index;
        cmd.b     = i_second_index;
        cmd.vx    = i_vec_x;
        cmd.vy    = i_vec_y;
        cmd.vz    = i_vec_z;
        cmd.mos   = i_mass_or_stiffness;
        cmd.rest  = i_rest_length;
        cmd.cdamp = i_spring_damping;
    end

    assign o_ready     = r_cnt != (PW+1)'(QUEUE_DEPTH);
    assign push        = i_valid && o_ready && keep;
    assign o_cmd_valid = r_cnt != '0;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_cmd_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(i_cmd_pop);
        end
    end
endmodule
`default_nettype wire

[design/msstep_div.sv]
// bit-serial signed division of a 48-bit numerator by a positive 32-bit divisor
// quotient truncated toward zero and saturated; depends on msstep_pkg
`default_nettype none
module msstep_div
    import msstep_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [47:0] i_num,
    input  wire logic [31:0]        i_den,
    output logic                    o_done,
    output logic signed [31:0]      o_quot
);
    logic        r_busy, r_done, r_neg;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem, r_den;
    logic [47:0] r_mag;
    logic [32:0] rem_sh, rem_sub;
    logic        take;

    assign rem_sh  = {r_rem, r_mag[47]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign take    = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[47];
            r_mag <= i_num[47] ? 48'(-i_num) : 48'(i_num);
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= take ? rem_sub[31:0] : rem_sh[31:0];
            r_mag <= {r_mag[46:0], take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && r_cnt == 6'd47;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 6'd47) r_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        if (r_neg) o_quot = sat32(-66'(signed'({1'b0, r_mag})));
        else       o_quot = sat32(66'(signed'({1'b0, r_mag})));
    end

    assign o_done = r_done;
endmodule
`default_nettype wire

[design/msstep_sqrt.sv]
// digit-by-digit integer square root of a 64-bit value, two bits per cycle
// depends on msstep_pkg
`default_nettype none
module msstep_sqrt
    import msstep_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_val,
    output logic             o_done,
    output logic [31:0]      o_root
);
    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_val;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [35:0] rem_sh, trial;
    logic        take;

    assign rem_sh = {r_rem, r_val[63:62]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[61:0], 2'b00};
            r_rem  <= take ? 34'(rem_sh - trial) : 34'(rem_sh);
            r_root <= {r_root[30:0], take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && r_cnt == 5'd31;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'd31) r_busy <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
`default_nettype wire

[design/msstep_back.sv]
// back end: particle tables, shared multiplier, sequencer for load, spring and integrate
// depends on msstep_pkg, msstep_div, msstep_sqrt and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module msstep_back
    import msstep_pkg::*;
#(
    parameter int PARTICLE_COUNT = PARTICLE_COUNT_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_pop,
    input  wire t_cmd          i_cmd,
    input  wire t_cfg          i_cfg,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [9:0]         o_particle_index,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic               o_pinned
);
    localparam int AW = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;

    logic [95:0] mem_pos  [PARTICLE_COUNT];
    logic [95:0] mem_vel  [PARTICLE_COUNT];
    logic [95:0] mem_frc  [PARTICLE_COUNT];
    logic [30:0] mem_mass [PARTICLE_COUNT];

    t_state             r_state, n_state, r_ret, n_ret;
    logic [1:0]         r_i, n_i;
    t_cmd               r_cmd, n_cmd;
    logic signed [32:0] r_ma, n_ma, r_mb, n_mb;
    logic signed [65:0] r_prod;
    logic signed [31:0] r_pa [3], n_pa [3];
    logic signed [31:0] r_va [3], n_va [3];
    logic signed [31:0] r_vb [3], n_vb [3];
    logic signed [31:0] r_fa [3], n_fa [3];
    logic signed [31:0] r_fb [3], n_fb [3];
    logic signed [31:0] r_d  [3], n_d  [3];
    logic signed [31:0] r_u  [3], n_u  [3];
    logic [63:0]        r_s, n_s;
    logic [31:0]        r_len, n_len;
    logic signed [31:0] r_fe, n_fe, r_dot, n_dot, r_fv, n_fv, r_t, n_t;
    logic [30:0]        r_m, n_m;
    logic               r_pin, n_pin;
    logic               r_ovalid, n_ovalid, r_opin, n_opin;
    logic [9:0]         r_oidx, n_oidx;
    logic signed [31:0] r_opos [3], n_opos [3];

    logic [95:0] r_qpos, r_qvel, r_qfrc;
    logic [30:0] r_qmass;
    logic [AW-1:0] rd_addr, wr_addr;
    logic        we_pos, we_vel, we_frc, we_mass;
    logic [95:0] wd_pos, wd_vel, wd_frc;

    logic               div_start, div_done, sqrt_start, sqrt_done;
    logic signed [47:0] div_num;
    logic [31:0]        div_den, sqrt_root;
    logic signed [31:0] div_quot;

    logic [32:0]        rest3;
    logic signed [33:0] ext_raw;
    logic signed [31:0] ext;
    logic signed [31:0] pq;

    assign rest3   = {2'b00, r_cmd.rest} + {1'b0, r_cmd.rest, 1'b0};
    assign ext_raw = signed'({2'b00, r_len}) - signed'({3'b000, rest3[32:2]});
    assign ext     = sat32(66'(ext_raw));
    assign pq      = qsat(r_prod);

    msstep_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    msstep_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_val   (r_s),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    always_ff @(posedge i_clk) begin
        if (we_pos)  mem_pos[wr_addr]  <= wd_pos;
        if (we_vel)  mem_vel[wr_addr]  <= wd_vel;
        if (we_frc)  mem_frc[wr_addr]  <= wd_frc;
        if (we_mass) mem_mass[wr_addr] <= r_cmd.mos;
        r_qpos  <= mem_pos[rd_addr];
        r_qvel  <= mem_vel[rd_addr];
        r_qfrc  <= mem_frc[rd_addr];
        r_qmass <= mem_mass[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_ma * r_mb;
    end

    always_comb begin
        logic signed [31:0] f, nv, tot, vsel;
        f    = '0;
        nv   = '0;
        tot  = '0;
        vsel = '0;
        n_state  = r_state;
        n_ret    = r_ret;
        n_i      = r_i;
        n_cmd    = r_cmd;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_pa     = r_pa;
        n_va     = r_va;
        n_vb     = r_vb;
        n_fa     = r_fa;
        n_fb     = r_fb;
        n_d      = r_d;
        n_u      = r_u;
        n_s      = r_s;
        n_len    = r_len;
        n_fe     = r_fe;
        n_dot    = r_dot;
        n_fv     = r_fv;
        n_t      = r_t;
        n_m      = r_m;
        n_pin    = r_pin;
        n_ovalid = r_ovalid && !i_ready;
        n_opin   = r_opin;
        n_oidx   = r_oidx;
        n_opos   = r_opos;
        o_cmd_pop  = 1'b0;
        rd_addr    = AW'(r_cmd.a);
        wr_addr    = AW'(r_cmd.a);
        we_pos     = 1'b0;
        we_vel     = 1'b0;
        we_frc     = 1'b0;
        we_mass    = 1'b0;
        wd_pos     = {r_pa[2], r_pa[1], r_pa[0]};
        wd_vel     = {r_va[2], r_va[1], r_va[0]};
        wd_frc     = {r_fa[2], r_fa[1], r_fa[0]};
        div_start  = 1'b0;
        div_num    = {r_d[r_i], 16'd0};
        div_den    = r_len;
        sqrt_start = 1'b0;
        case (r_i)
            2'd0:    vsel = r_cmd.vx;
            2'd1:    vsel = r_cmd.vy;
            default: vsel = r_cmd.vz;
        endcase

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd = i_cmd;
                    n_i = '0;
                    unique case (i_cmd.mode)
                        MODE_LOAD:   n_state = S_LD_WR;
                        MODE_SPRING: n_state = S_SP_RDA;
                        MODE_INTEG:  n_state = S_IN_RD;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_LD_WR: begin
                we_pos  = 1'b1;
                we_vel  = 1'b1;
                we_frc  = 1'b1;
                we_mass = 1'b1;
                wd_pos  = {r_cmd.vz, r_cmd.vy, r_cmd.vx};
                wd_vel  = '0;
                wd_frc  = '0;
                n_state = S_IDLE;
            end
            S_MULW: n_state = r_ret;
            S_SP_RDA: n_state = S_SP_RDB;
            S_SP_RDB: begin
                rd_addr = AW'(r_cmd.b);
                for (int k = 0; k < 3; k++) begin
                    n_pa[k] = signed'(r_qpos[32*k +: 32]);
                    n_va[k] = signed'(r_qvel[32*k +: 32]);
                    n_fa[k] = signed'(r_qfrc[32*k +: 32]);
                end
                n_state = S_SP_GETB;
            end
            S_SP_GETB: begin
                for (int k = 0; k < 3; k++) begin
                    n_d[k]  = sat32(66'(signed'(r_qpos[32*k +: 32])) - 66'(r_pa[k]));
                    n_vb[k] = signed'(r_qvel[32*k +: 32]);
                    n_fb[k] = signed'(r_qfrc[32*k +: 32]);
                end
                n_s = '0;
                n_i = '0;
                n_state = S_SP_SQ;
            end
            S_SP_SQ: begin
                n_ma = 33'(r_d[r_i]);
                n_mb = 33'(r_d[r_i]);
                n_ret = S_SP_SQACC;
                n_state = S_MULW;
            end
            S_SP_SQACC: begin
                n_s = r_s + r_prod[63:0];
                if (r_i == 2'd2) begin
                    n_state = S_SP_CHK;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_SP_SQ;
                end
            end
            S_SP_CHK: begin
                if (r_s == 64'd0) begin
                    n_state = S_IDLE;
                end else begin
                    sqrt_start = 1'b1;
                    n_state = S_SP_SQRTW;
                end
            end
            S_SP_SQRTW: begin
                if (sqrt_done) begin
                    n_len = sqrt_root;
                    n_i = '0;
                    n_state = S_SP_DIV;
                end
            end
            S_SP_DIV: begin
                div_start = 1'b1;
                n_state = S_SP_DIVW;
            end
            S_SP_DIVW: begin
                if (div_done) begin
                    n_u[r_i] = div_quot;
                    if (r_i == 2'd2) begin
                        n_state = S_SP_FE;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_state = S_SP_DIV;
                    end
                end
            end
            S_SP_FE: begin
                n_ma = signed'({2'b00, r_cmd.mos});
                n_mb = 33'(ext);
                n_ret = S_SP_FEG;
                n_state = S_MULW;
            end
            S_SP_FEG: begin
                n_fe = pq;
                n_dot = '0;
                n_i = '0;
                n_state = S_SP_DOT;
            end
            S_SP_DOT: begin
                n_ma = 33'(sat32(66'(r_va[r_i]) - 66'(r_vb[r_i])));
                n_mb = 33'(r_u[r_i]);
                n_ret = S_SP_DOTACC;
                n_state = S_MULW;
            end
            S_SP_DOTACC: begin
                n_dot = sat32(66'(r_dot) + 66'(pq));
                if (r_i == 2'd2) begin
                    n_state = S_SP_FV;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_SP_DOT;
                end
            end
            S_SP_FV: begin
                n_ma = signed'({2'b00, r_cmd.cdamp});
                n_mb = 33'(r_dot);
                n_ret = S_SP_FVG;
                n_state = S_MULW;
            end
            S_SP_FVG: begin
                n_fv = pq;
                n_i = '0;
                n_state = S_SP_F1;
            end
            S_SP_F1: begin
                n_ma = 33'(r_fe);
                n_mb = 33'(r_u[r_i]);
                n_ret = S_SP_F1G;
                n_state = S_MULW;
            end
            S_SP_F1G: begin
                n_t = pq;
                n_ma = 33'(r_fv);
                n_mb = 33'(r_u[r_i]);
                n_ret = S_SP_F2G;
                n_state = S_MULW;
            end
            S_SP_F2G: begin
                f = sat32(66'(r_t) + 66'(pq));
                n_fa[r_i] = sat32(66'(r_fa[r_i]) + 66'(f));
                n_fb[r_i] = sat32(66'(r_fb[r_i]) - 66'(f));
                if (r_i == 2'd2) begin
                    n_state = S_SP_WRA;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_SP_F1;
                end
            end
            S_SP_WRA: begin
                we_frc = 1'b1;
                n_state = S_SP_WRB;
            end
            S_SP_WRB: begin
                we_frc  = 1'b1;
                wr_addr = AW'(r_cmd.b);
                wd_frc  = {r_fb[2], r_fb[1], r_fb[0]};
                n_state = S_IDLE;
            end
            S_IN_RD: n_state = S_IN_GET;
            S_IN_GET: begin
                for (int k = 0; k < 3; k++) begin
                    n_pa[k] = signed'(r_qpos[32*k +: 32]);
                    n_va[k] = signed'(r_qvel[32*k +: 32]);
                    n_fa[k] = signed'(r_qfrc[32*k +: 32]);
                    n_u[k]  = '0;
                end
                n_m = r_qmass;
                n_pin = r_qmass == '0;
                n_i = '0;
                n_state = (r_qmass == '0) ? S_IN_V : S_IN_DIV;
            end
            S_IN_DIV: begin
                tot = sat32(66'(r_fa[r_i]) + 66'(vsel));
                div_num = {tot, 16'd0};
                div_den = {1'b0, r_m};
                div_start = 1'b1;
                n_state = S_IN_DIVW;
            end
            S_IN_DIVW: begin
                if (div_done) begin
                    n_u[r_i] = div_quot;
                    if (r_i == 2'd2) begin
                        n_i = '0;
                        n_state = S_IN_V;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_state = S_IN_DIV;
                    end
                end
            end
            S_IN_V: begin
                n_ma = signed'({26'd0, i_cfg.dt});
                n_mb = 33'(r_u[r_i]);
                n_ret = S_IN_VG;
                n_state = S_MULW;
            end
            S_IN_VG: begin
                nv = sat32(66'(r_va[r_i]) + 66'(pq));
                n_ma = 33'(nv);
                n_mb = signed'({16'd0, i_cfg.damp});
                n_ret = S_IN_DG;
                n_state = S_MULW;
            end
            S_IN_DG: begin
                n_va[r_i] = pq;
                n_ma = 33'(pq);
                n_mb = signed'({26'd0, i_cfg.dt});
                n_ret = S_IN_PG;
                n_state = S_MULW;
            end
            S_IN_PG: begin
                n_pa[r_i] = sat32(66'(r_pa[r_i]) + 66'(pq));
                if (r_i == 2'd2) begin
                    n_state = S_IN_WR;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_IN_V;
                end
            end
            S_IN_WR: begin
                we_pos = 1'b1;
                we_vel = 1'b1;
                we_frc = !r_pin;
                wd_frc = '0;
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_oidx   = r_cmd.a;
                    n_opos   = r_pa;
                    n_opin   = r_pin;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ret  <= n_ret;
        r_i    <= n_i;
        r_cmd  <= n_cmd;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_pa   <= n_pa;
        r_va   <= n_va;
        r_vb   <= n_vb;
        r_fa   <= n_fa;
        r_fb   <= n_fb;
        r_d    <= n_d;
        r_u    <= n_u;
        r_s    <= n_s;
        r_len  <= n_len;
        r_fe   <= n_fe;
        r_dot  <= n_dot;
        r_fv   <= n_fv;
        r_t    <= n_t;
        r_m    <= n_m;
        r_pin  <= n_pin;
        r_opin <= n_opin;
        r_oidx <= n_oidx;
        r_opos <= n_opos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_particle_index = r_oidx;
    assign o_pos_x          = r_opos[0];
    assign o_pos_y          = r_opos[1];
    assign o_pos_z          = r_opos[2];
    assign o_pinned         = r_opin;

    `MS_ASSERT(a_zero_len_skip, i_clk, i_rst_n, (r_state == S_SP_CHK && r_s == 64'd0) |=> (r_state == S_IDLE), "zero-length spring not skipped")
    `MS_NEVER(a_div_done_stray, i_clk, i_rst_n, div_done && !(r_state == S_SP_DIVW || r_state == S_IN_DIVW), "divider finished outside a wait state")
    `MS_NEVER(a_sqrt_done_stray, i_clk, i_rst_n, sqrt_done && r_state != S_SP_SQRTW, "square root finished outside its wait state")
endmodule
`default_nettype wire

[design/mass_spring_step_unit.sv]
// mass-spring step unit: request times are set by the bit-serial divider (one division a
// component; integrate skips it for a zero-mass particle), the square-root unit (spring only)
// and the shared multiplier (registered operands and product); a load only writes the tables;
// the back end runs one request at a time
// a two-entry request queue takes new requests while the back end works; needs msstep_pkg
// reset clears control state, sets time_step 66 and damping_factor 65536; tables are not cleared
`default_nettype none
module mass_spring_step_unit
    import msstep_pkg::*;
#(
    parameter int PARTICLE_COUNT = PARTICLE_COUNT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_mode,
    input  wire logic [9:0]         i_first_index,
    input  wire logic [9:0]         i_second_index,
    input  wire logic signed [31:0] i_vec_x,
    input  wire logic signed [31:0] i_vec_y,
    input  wire logic signed [31:0] i_vec_z,
    input  wire logic [30:0]        i_mass_or_stiffness,
    input  wire logic [30:0]        i_rest_length,
    input  wire logic [30:0]        i_spring_damping,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [9:0]              o_particle_index,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic signed [31:0]      o_pos_z,
    output logic                    o_pinned,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_index,
    input  wire logic [16:0]        i_cfg_data
);
    logic [6:0]  r_time_step;
    logic [16:0] r_damping;
    t_cfg        cfg;
    logic        cmd_valid, cmd_pop;
    t_cmd        cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TS_RESET;
            r_damping   <= DAMP_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TIME_STEP: r_time_step <= i_cfg_data[6:0];
                REG_DAMPING:   r_damping   <= i_cfg_data;
                default:       r_damping   <= r_damping;
            endcase
        end
    end

    assign cfg.dt   = (r_time_step < DT_MAX) ? r_time_step : DT_MAX;
    assign cfg.damp = r_damping;

    msstep_front #(
        .PARTICLE_COUNT (PARTICLE_COUNT)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_mode              (i_mode),
        .i_first_index       (i_first_index),
        .i_second_index      (i_second_index),
        .i_vec_x             (i_vec_x),
        .i_vec_y             (i_vec_y),
        .i_vec_z             (i_vec_z),
        .i_mass_or_stiffness (i_mass_or_stiffness),
        .i_rest_length       (i_rest_length),
        .i_spring_damping    (i_spring_damping),
        .o_cmd_valid         (cmd_valid),
        .i_cmd_pop           (cmd_pop),
        .o_cmd               (cmd)
    );

    msstep_back #(
        .PARTICLE_COUNT (PARTICLE_COUNT)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (cmd_valid),
        .o_cmd_pop        (cmd_pop),
        .i_cmd            (cmd),
        .i_cfg            (cfg),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_particle_index (o_particle_index),
        .o_pos_x          (o_pos_x),
        .o_pos_y          (o_pos_y),
        .o_pos_z          (o_pos_z),
        .o_pinned         (o_pinned)
    );
endmodule
`default_nettype wire
